FILE: rtl/lcdnw_pkg.sv
// ---------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants for the 4-bit LCD writer
// Request codes, bus timings, the power-up byte run and the structs that
// join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

  localparam int MODE_W   = 3;
  localparam int HOLD_W   = 14;
  localparam int STEP_W   = 3;
  localparam int PHASE_W  = 2;
  localparam int INIT_LEN = 5;

  localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CMD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DATA  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GOTO  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HOME  = 3'd5;

  localparam logic [HOLD_W-1:0] T_STROBE  = 14'd1;
  localparam logic [HOLD_W-1:0] T_SETTLE  = 14'd200;
  localparam logic [HOLD_W-1:0] T_EXEC    = 14'd2000;
  localparam logic [HOLD_W-1:0] T_POWERUP = 14'd15000;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] CMD_LINE1   = 8'hC0;

  localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};

  localparam logic [PHASE_W-1:0] PH_HI_STROBE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HI_SETTLE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LO_STROBE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LO_EXEC   = 2'd3;

  typedef struct packed {
    logic               load;
    logic               emit;
    logic               last;
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] num_steps;
    logic              step_is_wait;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/lcdnw_ctrl.sv
// ---------------------------------------------------------------------------
// lcdnw_ctrl: request sequencer
// Walks the steps of a request, and the four bus phases of each byte step.
// ---------------------------------------------------------------------------
`default_nettype none

module lcdnw_ctrl
  import lcdnw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic               state;
  logic               state_next;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic               step_done;
  logic               final_phase;

  assign busy        = (state == S_RUN);
  assign step_done   = status.step_is_wait || (phase == PH_LO_EXEC);
  assign final_phase = step_done && (step == status.num_steps - STEP_W'(1));

  always_comb begin
    state_next = state;
    step_next  = step;
    phase_next = phase;
    cmd        = '0;
    cmd.step   = step;
    cmd.phase  = phase;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
          step_next  = '0;
          phase_next = '0;
        end
      end
      S_RUN: begin
        if (status.num_steps == '0) begin
          // request with nothing to send: drop it
          state_next = S_IDLE;
        end else begin
          cmd.emit = 1'b1;
          cmd.last = final_phase;
          if (final_phase) begin
            state_next = S_IDLE;
          end else if (step_done) begin
            step_next  = step + STEP_W'(1);
            phase_next = '0;
          end else begin
            phase_next = phase + PHASE_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcdnw_dp.sv
// ---------------------------------------------------------------------------
// lcdnw_dp: request register and phase generator
// Holds the request, decodes each step and registers the bus phase.
// ---------------------------------------------------------------------------
`default_nettype none

module lcdnw_dp
  import lcdnw_pkg::*;
#(
  parameter int COLUMNS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [7:0]        byte_value,
  input  wire logic [7:0]        column,
  input  wire logic [1:0]        line,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             status,
  output logic                   strobe,
  output logic [3:0]             nibble,
  output logic                   reg_select,
  output logic                   enable,
  output logic [HOLD_W-1:0]      hold_us,
  output logic                   last
);

  logic [MODE_W-1:0] req_mode;
  logic [7:0]        req_byte;
  logic [7:0]        req_col;
  logic [1:0]        req_line;

  logic              goto_ok;
  logic [7:0]        goto_addr;
  logic              st_wait;
  logic [7:0]        st_byte;
  logic              st_rs;
  logic [3:0]        wait_nib;
  logic [HOLD_W-1:0] wait_hold;
  logic [STEP_W-1:0] init_idx;

  logic [3:0]        ph_nib;
  logic              ph_en;
  logic [HOLD_W-1:0] ph_hold;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_byte <= byte_value;
      req_col  <= column;
      req_line <= line;
    end
  end

  assign goto_ok   = (req_line[1] == 1'b0) && (req_col < 8'(COLUMNS));
  assign goto_addr = (req_line[0] ? CMD_LINE1 : CMD_DDRAM) | req_col;
  assign init_idx  = cmd.step - STEP_W'(1);

  // decode the current step of the request
  always_comb begin
    status.num_steps = '0;
    st_wait   = 1'b0;
    st_byte   = CMD_DDRAM;
    st_rs     = 1'b0;
    wait_nib  = 4'h1;
    wait_hold = T_EXEC;
    unique case (req_mode)
      MODE_INIT: begin
        status.num_steps = STEP_W'(INIT_LEN + 2);
        if (cmd.step == '0) begin
          st_wait   = 1'b1;
          wait_nib  = 4'h0;
          wait_hold = T_POWERUP;
        end else if (cmd.step == STEP_W'(INIT_LEN + 1)) begin
          st_wait = 1'b1;
        end else begin
          st_byte = INIT_SEQ[init_idx];
        end
      end
      MODE_CMD: begin
        status.num_steps = STEP_W'(1);
        st_byte = req_byte;
      end
      MODE_DATA: begin
        status.num_steps = STEP_W'(1);
        st_byte = req_byte;
        st_rs   = 1'b1;
      end
      MODE_CLEAR: begin
        status.num_steps = STEP_W'(3);
        if (cmd.step == '0) begin
          st_byte = CMD_CLEAR;
        end else if (cmd.step == STEP_W'(1)) begin
          st_wait = 1'b1;
        end else begin
          st_byte = CMD_DDRAM;
        end
      end
      MODE_GOTO: begin
        status.num_steps = goto_ok ? STEP_W'(1) : '0;
        st_byte = goto_addr;
      end
      MODE_HOME: begin
        status.num_steps = STEP_W'(1);
        st_byte = CMD_DDRAM;
      end
      default: status.num_steps = '0;
    endcase
    status.step_is_wait = st_wait;
  end

  // pick the pin levels of the current phase
  always_comb begin
    ph_nib  = st_byte[7:4];
    ph_en   = 1'b0;
    ph_hold = T_SETTLE;
    if (st_wait) begin
      ph_nib  = wait_nib;
      ph_hold = wait_hold;
    end else begin
      unique case (cmd.phase)
        PH_HI_STROBE: begin
          ph_en   = 1'b1;
          ph_hold = T_STROBE;
        end
        PH_HI_SETTLE: ph_hold = T_SETTLE;
        PH_LO_STROBE: begin
          ph_nib  = st_byte[3:0];
          ph_en   = 1'b1;
          ph_hold = T_STROBE;
        end
        PH_LO_EXEC: begin
          ph_nib  = st_byte[3:0];
          ph_hold = T_EXEC;
        end
        default: ph_hold = T_SETTLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      nibble     <= ph_nib;
      reg_select <= st_wait ? 1'b0 : st_rs;
      enable     <= ph_en;
      hold_us    <= ph_hold;
      last       <= cmd.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/char_lcd_nibble_writer.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit character LCD bus sequencer
// Turns display requests into timed pin phases for a 4-bit LCD bus.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive mode, byte_value, column and line and raise start;
//   the request transfers at the clock edge where start is high and busy is
//   low. Modes: init, command byte, data character, clear, goto, home.
//   Result channel: each pin phase appears for one cycle with strobe high,
//   carrying nibble, reg_select, enable, hold_us and last (final phase of the
//   request). The receiver cannot stall; the phase transfers on that cycle.
//   Phases: the first phase strobes from the datapath output register once
//   the controller has entered its run state, then one phase per cycle.
//   Busy stays high while a request's phases are stepped out, and rises also
//   for a request that yields nothing, so a new request is taken only once
//   the last one is through.
//   Goto with a line above 1 or a column of COLUMNS or more, and unused
//   modes, transfer but emit no phase.
//   Reset: synchronous, active high; drops any run in progress and clears
//   strobe. The block keeps nothing between requests.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer
  import lcdnw_pkg::*;
#(
  parameter int COLUMNS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [7:0]        byte_value,
  input  wire logic [7:0]        column,
  input  wire logic [1:0]        line,
  output logic                   strobe,
  output logic [3:0]             nibble,
  output logic                   reg_select,
  output logic                   enable,
  output logic [HOLD_W-1:0]      hold_us,
  output logic                   last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: owns busy and walks steps and phases
  lcdnw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // datapath: latches the request and registers each phase
  lcdnw_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .byte_value (byte_value),
    .column     (column),
    .line       (line),
    .cmd        (cmd),
    .status     (status),
    .strobe     (strobe),
    .nibble     (nibble),
    .reg_select (reg_select),
    .enable     (enable),
    .hold_us    (hold_us),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: dv/char_lcd_nibble_writer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_nibble_writer_tb: self-checking bench for the 4-bit LCD writer
// Sends display requests over the start/busy command channel and checks every
// pin phase that strobes out against a local model of the bus sequence. A
// short directed table comes first, then weighted random requests.
// ---------------------------------------------------------------------------

module char_lcd_nibble_writer_tb;
  import lcdnw_pkg::*;

  localparam int LCD_COLUMNS = 16;
  localparam int N_RANDOM    = 140;
  localparam int N_DIRECTED  = 23;

  // Codes the block decodes to nothing
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  // How a directed row gets its expected phases
  typedef enum logic [1:0] {
    ROW_PREDICT, // work the phases out with the bus model
    ROW_BYTE,    // one byte on the bus, typed in below
    ROW_SILENT   // request must produce no phase at all
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [MODE_W-1:0] mode;
    logic [7:0]        byte_value;
    logic [7:0]        column;
    logic [1:0]        line;
    logic [7:0]        bus_byte;
    logic              bus_rs;
  } stim_row_t;

  typedef struct packed {
    logic [3:0]        nibble;
    logic              reg_select;
    logic              enable;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } bus_phase_t;

  // Directed table: extremes of every field, every request, each silent case
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_PREDICT, MODE_INIT,   8'h00, 8'h00, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE,    MODE_CMD,    8'h00, 8'h00, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE,    MODE_CMD,    8'hFF, 8'hFF, 2'd3, 8'hFF, 1'b0},
    '{ROW_BYTE,    MODE_DATA,   8'h00, 8'h00, 2'd0, 8'h00, 1'b1},
    '{ROW_BYTE,    MODE_DATA,   8'hFF, 8'hFF, 2'd3, 8'hFF, 1'b1},
    '{ROW_PREDICT, MODE_DATA,   8'hA5, 8'h5A, 2'd1, 8'h00, 1'b0},
    '{ROW_PREDICT, MODE_DATA,   8'h5A, 8'hA5, 2'd2, 8'h00, 1'b0},
    '{ROW_PREDICT, MODE_CLEAR,  8'hFF, 8'hFF, 2'd3, 8'h00, 1'b0},
    '{ROW_BYTE,    MODE_GOTO,   8'hFF, 8'h00, 2'd0, 8'h80, 1'b0},
    '{ROW_BYTE,    MODE_GOTO,   8'h00, 8'h0F, 2'd1, 8'hCF, 1'b0},
    '{ROW_SILENT,  MODE_GOTO,   8'h00, 8'h10, 2'd0, 8'h00, 1'b0},
    '{ROW_SILENT,  MODE_GOTO,   8'h00, 8'hFF, 2'd1, 8'h00, 1'b0},
    '{ROW_SILENT,  MODE_GOTO,   8'h00, 8'h03, 2'd2, 8'h00, 1'b0},
    '{ROW_SILENT,  MODE_GOTO,   8'h00, 8'h00, 2'd3, 8'h00, 1'b0},
    '{ROW_BYTE,    MODE_GOTO,   8'h00, 8'h0F, 2'd0, 8'h8F, 1'b0},
    '{ROW_BYTE,    MODE_GOTO,   8'h00, 8'h00, 2'd1, 8'hC0, 1'b0},
    '{ROW_BYTE,    MODE_HOME,   8'hFF, 8'hFF, 2'd3, 8'h80, 1'b0},
    '{ROW_SILENT,  MODE_SPARE6, 8'hFF, 8'hFF, 2'd3, 8'h00, 1'b0},
    '{ROW_SILENT,  MODE_SPARE7, 8'h00, 8'h00, 2'd0, 8'h00, 1'b0},
    '{ROW_PREDICT, MODE_CMD,    8'h28, 8'h00, 2'd0, 8'h00, 1'b0},
    '{ROW_PREDICT, MODE_INIT,   8'hFF, 8'hFF, 2'd3, 8'h00, 1'b0},
    '{ROW_PREDICT, MODE_CLEAR,  8'h00, 8'h00, 2'd0, 8'h00, 1'b0},
    '{ROW_PREDICT, MODE_GOTO,   8'h3C, 8'h07, 2'd1, 8'h00, 1'b0}
  };

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode;
  logic [7:0]        byte_value;
  logic [7:0]        column;
  logic [1:0]        line;
  logic              strobe;
  logic [3:0]        nibble;
  logic              reg_select;
  logic              enable;
  logic [HOLD_W-1:0] hold_us;
  logic              last;

  // Phases of the request being modelled, then the queue still owed by the DUT
  bus_phase_t req_run [$];
  bus_phase_t pending_phases [$];
  bus_phase_t want;
  bus_phase_t got;
  int         mismatches;

  char_lcd_nibble_writer #(
    .COLUMNS (LCD_COLUMNS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .byte_value (byte_value),
    .column     (column),
    .line       (line),
    .strobe     (strobe),
    .nibble     (nibble),
    .reg_select (reg_select),
    .enable     (enable),
    .hold_us    (hold_us),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: the slowest legal run is far below this
  initial begin
    #5_000_000;
    $display("char_lcd_nibble_writer_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Bus model
  // ---------------------------------------------------------------------------

  // Append one phase to the current run; the last flag is set when it closes
  function automatic void add_phase(logic [3:0] nib, logic rs, logic en,
                                    logic [HOLD_W-1:0] hold);
    bus_phase_t ph;
    ph.nibble     = nib;
    ph.reg_select = rs;
    ph.enable     = en;
    ph.hold_us    = hold;
    ph.last       = 1'b0;
    req_run.push_back(ph);
  endfunction

  // High nibble first: strobe, settle, then low nibble strobe and execute wait
  function automatic void add_bus_byte(logic [7:0] b, logic rs);
    add_phase(b[7:4], rs, 1'b1, T_STROBE);
    add_phase(b[7:4], rs, 1'b0, T_SETTLE);
    add_phase(b[3:0], rs, 1'b1, T_STROBE);
    add_phase(b[3:0], rs, 1'b0, T_EXEC);
  endfunction

  // Mark the final phase and hand the run over to the checker
  function automatic void close_run();
    bus_phase_t tail;
    if (req_run.size() > 0) begin
      tail = req_run.pop_back();
      tail.last = 1'b1;
      req_run.push_back(tail);
    end
    foreach (req_run[k]) pending_phases.push_back(req_run[k]);
    req_run.delete();
  endfunction

  function automatic void model_request(logic [MODE_W-1:0] m, logic [7:0] bv,
                                        logic [7:0] col, logic [1:0] ln);
    case (m)
      MODE_INIT: begin
        // Power-up wait drives the data lines low; the closing wait keeps
        // the low nibble of the last init byte
        add_phase(4'h0, 1'b0, 1'b0, T_POWERUP);
        for (int k = 0; k < INIT_LEN; k++) add_bus_byte(INIT_SEQ[k], 1'b0);
        add_phase(INIT_SEQ[INIT_LEN-1][3:0], 1'b0, 1'b0, T_EXEC);
      end
      MODE_CMD:  add_bus_byte(bv, 1'b0);
      MODE_DATA: add_bus_byte(bv, 1'b1);
      MODE_CLEAR: begin
        add_bus_byte(CMD_CLEAR, 1'b0);
        add_phase(CMD_CLEAR[3:0], 1'b0, 1'b0, T_EXEC);
        add_bus_byte(CMD_DDRAM, 1'b0);
      end
      MODE_GOTO: begin
        // Off-screen targets are dropped without a phase
        if (ln <= 2'd1 && int'(col) < LCD_COLUMNS)
          add_bus_byte((ln == 2'd1 ? CMD_LINE1 : CMD_DDRAM) | col, 1'b0);
      end
      MODE_HOME: add_bus_byte(CMD_DDRAM, 1'b0);
      default: ;
    endcase
    close_run();
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: fields change on the falling edge, transfer is seen on
  // the rising edge with start high and busy low
  // ---------------------------------------------------------------------------
  task automatic send_request(row_kind_t kind, logic [MODE_W-1:0] m,
                              logic [7:0] bv, logic [7:0] col, logic [1:0] ln,
                              logic [7:0] bus_byte, logic bus_rs);
    mode       = m;
    byte_value = bv;
    column     = col;
    line       = ln;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    case (kind)
      ROW_PREDICT: model_request(m, bv, col, ln);
      ROW_BYTE: begin
        add_bus_byte(bus_byte, bus_rs);
        close_run();
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop start for a random burst, now and then
  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 2) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Phase checker: every strobe must match the oldest owed phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && strobe) begin
      got = '{nibble, reg_select, enable, hold_us, last};
      if (pending_phases.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected phase expected none, actual nib=%h rs=%b en=%b hold=%0d last=%b",
                 $time, nibble, reg_select, enable, hold_us, last);
      end else begin
        want = pending_phases.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: phase mismatch expected nib=%h rs=%b en=%b hold=%0d last=%b",
                   $time, want.nibble, want.reg_select, want.enable, want.hold_us,
                   want.last);
          $display("%0t:                  actual nib=%h rs=%b en=%b hold=%0d last=%b",
                   $time, got.nibble, got.reg_select, got.enable, got.hold_us,
                   got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [MODE_W-1:0] r_mode;
    logic [7:0]        r_col;
    logic [1:0]        r_line;
    int                pick;
    bit                calm;

    mismatches = 0;
    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_INIT;
    byte_value = 8'h00;
    column     = 8'h00;
    line       = 2'd0;

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table with occasional gaps between transfers
    foreach (DIRECTED[k]) begin
      send_request(DIRECTED[k].kind, DIRECTED[k].mode, DIRECTED[k].byte_value,
                   DIRECTED[k].column, DIRECTED[k].line, DIRECTED[k].bus_byte,
                   DIRECTED[k].bus_rs);
      maybe_idle(1'b1);
    end

    // Random requests: mostly real display traffic, some off-screen gotos and
    // dead codes; unused fields are always random so every bit toggles
    for (int i = 0; i < N_RANDOM; i++) begin
      pick   = $urandom_range(0, 99);
      r_col  = 8'($urandom_range(0, 255));
      r_line = 2'($urandom_range(0, 3));
      if (pick < 6)       r_mode = MODE_INIT;
      else if (pick < 26) r_mode = MODE_CMD;
      else if (pick < 50) r_mode = MODE_DATA;
      else if (pick < 58) r_mode = MODE_CLEAR;
      else if (pick < 86) begin
        r_mode = MODE_GOTO;
        if ($urandom_range(0, 3) != 0) r_col = 8'($urandom_range(0, LCD_COLUMNS - 1));
        if ($urandom_range(0, 4) != 0) r_line = 2'($urandom_range(0, 1));
      end
      else if (pick < 94) r_mode = MODE_HOME;
      else r_mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE6 : MODE_SPARE7;

      send_request(ROW_PREDICT, r_mode, 8'($urandom_range(0, 255)), r_col, r_line,
                   8'h00, 1'b0);

      // Every third block of sixteen runs back to back, and the tail is flat out
      calm = ((i / 16) % 3 == 2) || (i >= N_RANDOM - 40);
      maybe_idle(!calm);
    end
    start = 1'b0;

    // Drain: let every owed phase arrive, then watch for strays
    for (int k = 0; k < 2000 && pending_phases.size() > 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_phases.size() > 0) begin
      mismatches++;
      $display("%0t: %0d phases expected but never strobed, next nib=%h hold=%0d",
               $time, pending_phases.size(), pending_phases[0].nibble,
               pending_phases[0].hold_us);
    end

    if (mismatches == 0) begin
      $display("char_lcd_nibble_writer_tb passed");
    end else begin
      $display("char_lcd_nibble_writer_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcdnw_pkg.sv
rtl/lcdnw_ctrl.sv
rtl/lcdnw_dp.sv
rtl/char_lcd_nibble_writer.sv
dv/char_lcd_nibble_writer_tb.sv
